/* rtl/core/sacd_pkg.sv */
// ============================================================================
// sacd_pkg - shared definitions for the synchronous AM / C-QUAM detector
// Constants, register map, CORDIC angle table and controller/datapath types.
// ============================================================================
package sacd_pkg;

	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_SAMPLE_BITS   = 16;

	localparam int GUARD_BITS  = 8;
	localparam int DC_EXTRA    = 6;
	localparam int ANGLE_TAB_LEN = 24;
	localparam int ANGLE_IDX_W = 5;

	localparam logic [15:0] INV_CORDIC_GAIN = 16'd39797;
	localparam logic [31:0] ACC_LIMIT       = 32'd536870912;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_PROP_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_INT_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_OFFSET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DC_POLE        = 3'd4;

	localparam logic        RST_STEREO_MODE    = 1'b0;
	localparam logic [23:0] RST_LOOP_PROP_GAIN = 24'd155268;
	localparam logic [23:0] RST_LOOP_INT_GAIN  = 24'd719;
	localparam logic [31:0] RST_FREQ_OFFSET    = 32'd0;
	localparam logic [15:0] RST_DC_POLE        = 16'd65470;

	typedef struct packed {
		logic load;
		logic rot_step;
		logic vec_init;
		logic vec_step;
		logic gain_mul;
		logic acc_upd;
		logic nco_upd;
		logic audio;
		logic dc_mul;
		logic dc_upd;
		logic dc_ch;
		logic out_load;
	} sacd_cmd_t;

	typedef struct packed {
		logic stereo;
	} sacd_sts_t;

	// atan(2^-i), 2^32 per turn
	function automatic logic [31:0] angle_at(input logic [ANGLE_IDX_W-1:0] idx);
		logic [31:0] a;
		begin
			case (idx)
				5'd0:  a = 32'd536870912;
				5'd1:  a = 32'd316933406;
				5'd2:  a = 32'd167458907;
				5'd3:  a = 32'd85004756;
				5'd4:  a = 32'd42667331;
				5'd5:  a = 32'd21354465;
				5'd6:  a = 32'd10679838;
				5'd7:  a = 32'd5340245;
				5'd8:  a = 32'd2670163;
				5'd9:  a = 32'd1335087;
				5'd10: a = 32'd667544;
				5'd11: a = 32'd333772;
				5'd12: a = 32'd166886;
				5'd13: a = 32'd83443;
				5'd14: a = 32'd41722;
				5'd15: a = 32'd20861;
				5'd16: a = 32'd10430;
				5'd17: a = 32'd5215;
				5'd18: a = 32'd2608;
				5'd19: a = 32'd1304;
				5'd20: a = 32'd652;
				5'd21: a = 32'd326;
				5'd22: a = 32'd163;
				5'd23: a = 32'd81;
				default: a = 32'd0;
			endcase
			return a;
		end
	endfunction

endpackage

/* rtl/core/sacd_if.sv */
// ============================================================================
// sacd_if - channel interfaces of the detector
// Sample input, audio output and configuration write channels.
// ============================================================================
interface sacd_in_if import sacd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_phase;
	logic signed [SAMPLE_BITS-1:0] quadrature;

	modport source (output valid, output in_phase, output quadrature, input ready);
	modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

interface sacd_out_if import sacd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS+1:0] left_out;
	logic signed [SAMPLE_BITS+1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sacd_cfg_if import sacd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sync_am_pll_cquam_detector_unit.sv */
// ============================================================================
// sync_am_pll_cquam_detector_unit - synchronous AM / C-QUAM stereo detector
// Phase-locked NCO derotation, PI carrier loop and DC-blocked audio outputs.
// ============================================================================
// A sample transaction is paced by the single shift-add CORDIC unit that runs
// the rotation pass and then the vectoring pass one micro-rotation per cycle;
// a stereo sample runs the DC blocker step twice, as the two stereo channels
// share one DC blocker. Samples are taken one at a time: in_ch.ready is high
// only between samples. The audio result sits in an output register, so the
// next sample is accepted while the previous result waits on out_ch.
// Configuration writes are always ready and must only be issued while no
// sample is in work.
module sync_am_pll_cquam_detector_unit import sacd_pkg::*; #(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
	input logic         clk,
	input logic         arst_n,
	sacd_in_if.sink     in_ch,
	sacd_out_if.source  out_ch,
	sacd_cfg_if.sink    cfg_ch
);

	sacd_cmd_t                        cmd;
	sacd_sts_t                        sts;
	logic [$clog2(CORDIC_STAGES)-1:0] iter;

	assign cfg_ch.ready = 1'b1;

	sacd_ctrl #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd),
		.iter      (iter)
	);

	sacd_datapath #(
		.CORDIC_STAGES (CORDIC_STAGES),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.iter       (iter),
		.sts        (sts),
		.cfg_we     (cfg_ch.valid),
		.cfg_index  (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.in_phase   (in_ch.in_phase),
		.quadrature (in_ch.quadrature),
		.left_out   (out_ch.left_out),
		.right_out  (out_ch.right_out)
	);

endmodule

/* rtl/core/sacd_datapath.sv */
// ============================================================================
// sacd_datapath - CORDIC, PI loop, NCO and DC blockers
// Shared shift-add CORDIC for rotation and vectoring, loop filter, audio
// matrix and one time-shared DC blocker with per-channel state.
// ============================================================================
module sacd_datapath import sacd_pkg::*; #(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
	parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sacd_cmd_t                            cmd,
	input  logic [$clog2(CORDIC_STAGES)-1:0]     iter,
	output sacd_sts_t                            sts,
	input  logic                                 cfg_we,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [CFG_DATA_W-1:0]                cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]        in_phase,
	input  logic signed [SAMPLE_BITS-1:0]        quadrature,
	output logic signed [SAMPLE_BITS+1:0]        left_out,
	output logic signed [SAMPLE_BITS+1:0]        right_out
);

	localparam int W  = SAMPLE_BITS + GUARD_BITS + 3;
	localparam int AW = SAMPLE_BITS + 2;
	localparam int DW = SAMPLE_BITS + 8;

	localparam logic signed [W:0]    AU_MAX = (W+1)'((1 <<< (AW-1)) - 1);
	localparam logic signed [W:0]    AU_MIN = -AU_MAX - 1;
	localparam logic signed [DW+1:0] DC_MAX = (DW+2)'((1 <<< (DW-1)) - 1);
	localparam logic signed [DW+1:0] DC_MIN = -DC_MAX - 1;
	localparam logic signed [33:0]   ACC_HI = 34'(ACC_LIMIT);
	localparam logic signed [33:0]   ACC_LO = -ACC_HI;

	localparam logic [1:0] CH_MONO  = 2'd0;
	localparam logic [1:0] CH_LEFT  = 2'd1;
	localparam logic [1:0] CH_RIGHT = 2'd2;

	// configuration
	logic        stereo_q;
	logic [23:0] kp_q;
	logic [23:0] ki_q;
	logic [31:0] freq_q;
	logic [15:0] pole_q;

	// loop state
	logic [31:0]        nco_q;
	logic signed [31:0] integ_q;

	// DC blocker state
	logic signed [AW-1:0] mono_pin_q, left_pin_q, right_pin_q;
	logic signed [DW-1:0] mono_pout_q, left_pout_q, right_pout_q;

	// working registers
	logic signed [W-1:0]    x_q, y_q, vx_q, vy_q;
	logic [31:0]            z_q, a_q;
	logic                   zero_q;
	logic signed [56:0]     prod_i_q, prod_p_q;
	logic [31:0]            acc_q;
	logic signed [W-1:0]    ir_q, qr_q;
	logic signed [AW-1:0]   au_a_q, au_b_q;
	logic signed [DW+16:0]  dprod_q;
	logic signed [AW-1:0]   res_a_q, res_b_q;
	logic signed [AW-1:0]   left_q, right_q;

	function automatic logic signed [AW-1:0] sat_au(input logic signed [W:0] v);
		logic signed [AW-1:0] r;
		begin
			if (v > AU_MAX)
				r = AU_MAX[AW-1:0];
			else if (v < AU_MIN)
				r = AU_MIN[AW-1:0];
			else
				r = v[AW-1:0];
			return r;
		end
	endfunction

	// input load and coarse half-turn flip
	logic signed [W-1:0] ld_xs, ld_ys;
	logic [31:0]         ld_z;
	logic                ld_flip;

	assign ld_xs   = W'(in_phase) <<< GUARD_BITS;
	assign ld_ys   = W'(quadrature) <<< GUARD_BITS;
	assign ld_z    = 32'd0 - nco_q;
	assign ld_flip = ($signed(ld_z) > 32'sd1073741824) || ($signed(ld_z) < -32'sd1073741824);

	// CORDIC micro-rotation
	logic [31:0]         ang;
	logic signed [W-1:0] rdx, rdy, vdx, vdy;

	assign ang = angle_at(ANGLE_IDX_W'(iter));
	assign rdx = y_q >>> iter;
	assign rdy = x_q >>> iter;
	assign vdx = vy_q >>> iter;
	assign vdy = vx_q >>> iter;

	// loop filter
	logic signed [56:0] prod_i, prod_p;
	logic signed [33:0] acc_raw, acc_c;
	logic [31:0]        nco_next;

	assign prod_i = $signed({1'b0, ki_q}) * $signed(a_q);
	assign prod_p = $signed({1'b0, kp_q}) * $signed(a_q);
	assign acc_raw = 34'($signed(prod_i_q[56:24])) + 34'(integ_q);

	always_comb begin
		acc_c = acc_raw;
		if (stereo_q) begin
			if (acc_raw > ACC_HI)
				acc_c = ACC_HI;
			else if (acc_raw < ACC_LO)
				acc_c = ACC_LO;
		end
	end

	assign nco_next = nco_q + freq_q + prod_p_q[55:24] + acc_q;

	// gain compensation
	logic signed [W+16:0] ir_prod, qr_prod;

	assign ir_prod = x_q * $signed({1'b0, INV_CORDIC_GAIN});
	assign qr_prod = y_q * $signed({1'b0, INV_CORDIC_GAIN});

	// audio matrix
	logic signed [W:0] diff_v, sum_v, mono_v;

	assign diff_v = ir_q - qr_q;
	assign sum_v  = ir_q + qr_q;
	assign mono_v = (W+1)'(ir_q) >>> GUARD_BITS;

	// shared DC blocker
	logic [1:0]            chan;
	logic signed [AW-1:0]  dc_x, dc_pin;
	logic signed [DW-1:0]  dc_pout;
	logic signed [AW:0]    dc_diff;
	logic signed [DW+1:0]  dc_sum;
	logic signed [DW-1:0]  dc_y;
	logic signed [DW+16:0] dprod;

	assign chan = cmd.dc_ch ? CH_RIGHT : (stereo_q ? CH_LEFT : CH_MONO);
	assign dc_x = cmd.dc_ch ? au_b_q : au_a_q;

	always_comb begin
		unique case (chan)
			CH_LEFT: begin
				dc_pin  = left_pin_q;
				dc_pout = left_pout_q;
			end
			CH_RIGHT: begin
				dc_pin  = right_pin_q;
				dc_pout = right_pout_q;
			end
			default: begin
				dc_pin  = mono_pin_q;
				dc_pout = mono_pout_q;
			end
		endcase
	end

	assign dprod   = $signed({1'b0, pole_q}) * dc_pout;
	assign dc_diff = dc_x - dc_pin;
	assign dc_sum  = ((DW+2)'(dc_diff) <<< DC_EXTRA) + (DW+2)'(dprod_q >>> 16);

	always_comb begin
		if (dc_sum > DC_MAX)
			dc_y = DC_MAX[DW-1:0];
		else if (dc_sum < DC_MIN)
			dc_y = DC_MIN[DW-1:0];
		else
			dc_y = dc_sum[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q     <= RST_STEREO_MODE;
			kp_q         <= RST_LOOP_PROP_GAIN;
			ki_q         <= RST_LOOP_INT_GAIN;
			freq_q       <= RST_FREQ_OFFSET;
			pole_q       <= RST_DC_POLE;
			nco_q        <= '0;
			integ_q      <= '0;
			mono_pin_q   <= '0;
			left_pin_q   <= '0;
			right_pin_q  <= '0;
			mono_pout_q  <= '0;
			left_pout_q  <= '0;
			right_pout_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STEREO_MODE:    stereo_q <= cfg_data[0];
					REG_LOOP_PROP_GAIN: kp_q     <= cfg_data[23:0];
					REG_LOOP_INT_GAIN:  ki_q     <= cfg_data[23:0];
					REG_FREQ_OFFSET:    freq_q   <= cfg_data[31:0];
					REG_DC_POLE:        pole_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.acc_upd)
				integ_q <= acc_c[31:0];
			if (cmd.nco_upd)
				nco_q <= nco_next;
			if (cmd.dc_upd) begin
				unique case (chan)
					CH_LEFT: begin
						left_pin_q  <= dc_x;
						left_pout_q <= dc_y;
					end
					CH_RIGHT: begin
						right_pin_q  <= dc_x;
						right_pout_q <= dc_y;
					end
					default: begin
						mono_pin_q  <= dc_x;
						mono_pout_q <= dc_y;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= ld_flip ? -ld_xs : ld_xs;
			y_q <= ld_flip ? -ld_ys : ld_ys;
			z_q <= ld_flip ? (ld_z + 32'h8000_0000) : ld_z;
		end
		if (cmd.rot_step) begin
			if (!z_q[31]) begin
				x_q <= x_q - rdx;
				y_q <= y_q + rdy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + rdx;
				y_q <= y_q - rdy;
				z_q <= z_q + ang;
			end
		end
		if (cmd.vec_init) begin
			zero_q <= (x_q == '0) && (y_q == '0);
			if (x_q < 0) begin
				vx_q <= -x_q;
				vy_q <= -y_q;
				a_q  <= 32'h8000_0000;
			end else begin
				vx_q <= x_q;
				vy_q <= y_q;
				a_q  <= 32'd0;
			end
		end
		if (cmd.vec_step && !zero_q) begin
			if (vy_q >= 0) begin
				vx_q <= vx_q + vdx;
				vy_q <= vy_q - vdy;
				a_q  <= a_q + ang;
			end else begin
				vx_q <= vx_q - vdx;
				vy_q <= vy_q + vdy;
				a_q  <= a_q - ang;
			end
		end
		if (cmd.gain_mul) begin
			prod_i_q <= prod_i;
			prod_p_q <= prod_p;
		end
		if (cmd.acc_upd) begin
			acc_q <= acc_c[31:0];
			ir_q  <= ir_prod[W+15:16];
			qr_q  <= qr_prod[W+15:16];
		end
		if (cmd.audio) begin
			if (stereo_q) begin
				au_a_q <= sat_au(diff_v >>> (GUARD_BITS + 1));
				au_b_q <= sat_au(sum_v >>> (GUARD_BITS + 1));
			end else begin
				au_a_q <= sat_au(mono_v);
			end
		end
		if (cmd.dc_mul)
			dprod_q <= dprod;
		if (cmd.dc_upd) begin
			if (cmd.dc_ch)
				res_b_q <= dc_y[DW-1:DC_EXTRA];
			else
				res_a_q <= dc_y[DW-1:DC_EXTRA];
		end
		if (cmd.out_load) begin
			left_q  <= res_a_q;
			right_q <= stereo_q ? res_b_q : '0;
		end
	end

	assign sts.stereo = stereo_q;
	assign left_out   = left_q;
	assign right_out  = right_q;

endmodule

/* rtl/core/sacd_ctrl.sv */
// ============================================================================
// sacd_ctrl - sequencer of the detector
// Steps the datapath through both CORDIC passes, the loop update and the
// DC blockers, and owns the handshakes of the sample and audio channels.
// ============================================================================
module sacd_ctrl import sacd_pkg::*; #(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	input  sacd_sts_t                        sts,
	output sacd_cmd_t                        cmd,
	output logic [$clog2(CORDIC_STAGES)-1:0] iter
);

	localparam int CW = $clog2(CORDIC_STAGES);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ROT      = 4'd1;
	localparam logic [3:0] ST_VEC_INIT = 4'd2;
	localparam logic [3:0] ST_VEC      = 4'd3;
	localparam logic [3:0] ST_GAIN     = 4'd4;
	localparam logic [3:0] ST_ACC      = 4'd5;
	localparam logic [3:0] ST_NCO      = 4'd6;
	localparam logic [3:0] ST_AUDIO    = 4'd7;
	localparam logic [3:0] ST_DC_MUL   = 4'd8;
	localparam logic [3:0] ST_DC_UPD   = 4'd9;
	localparam logic [3:0] ST_OUT      = 4'd10;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] iter_q, iter_d;
	logic          ch_q, ch_d;
	logic          out_valid_q;
	logic          iter_last;

	assign iter_last = (iter_q == CW'(CORDIC_STAGES - 1));

	always_comb begin
		cmd       = '0;
		cmd.dc_ch = ch_q;
		state_d   = state_q;
		iter_d    = iter_q;
		ch_d      = ch_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					iter_d   = '0;
					state_d  = ST_ROT;
				end
			end
			ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (iter_last) begin
					iter_d  = '0;
					state_d = ST_VEC_INIT;
				end else begin
					iter_d = iter_q + CW'(1);
				end
			end
			ST_VEC_INIT: begin
				cmd.vec_init = 1'b1;
				state_d      = ST_VEC;
			end
			ST_VEC: begin
				cmd.vec_step = 1'b1;
				if (iter_last) begin
					iter_d  = '0;
					state_d = ST_GAIN;
				end else begin
					iter_d = iter_q + CW'(1);
				end
			end
			ST_GAIN: begin
				cmd.gain_mul = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_upd = 1'b1;
				state_d     = ST_NCO;
			end
			ST_NCO: begin
				cmd.nco_upd = 1'b1;
				state_d     = ST_AUDIO;
			end
			ST_AUDIO: begin
				cmd.audio = 1'b1;
				ch_d      = 1'b0;
				state_d   = ST_DC_MUL;
			end
			ST_DC_MUL: begin
				cmd.dc_mul = 1'b1;
				state_d    = ST_DC_UPD;
			end
			ST_DC_UPD: begin
				cmd.dc_upd = 1'b1;
				if (sts.stereo && !ch_q) begin
					ch_d    = 1'b1;
					state_d = ST_DC_MUL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
			ch_q    <= ch_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign iter      = iter_q;

`ifndef SYNTH
	a_load_starts_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q == ST_ROT && iter_q == '0))
		else $error("sample transaction did not start the rotation pass");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rot_step, cmd.vec_init, cmd.vec_step, cmd.gain_mul,
			cmd.acc_upd, cmd.nco_upd, cmd.audio, cmd.dc_mul, cmd.dc_upd, cmd.out_load}))
		else $error("more than one datapath operation issued");

	a_vec_after_full_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VEC_INIT) |-> ($past(state_q) == ST_ROT && $past(iter_last)))
		else $error("vectoring started before rotation completed");

	a_second_ch_stereo: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dc_upd && ch_q) |-> sts.stereo)
		else $error("right channel blocker updated in mono");
`endif

endmodule
